@@ hw/rtl/gcrsd_pkg.sv @@
package gcrsd_pkg;

   // Sector geometry
   localparam int SECTOR_SIZE     = 256;
   localparam int LOW_BIT_NIBBLES = 86;
   localparam int SLOT_W          = $clog2(LOW_BIT_NIBBLES);

   // Prologue and translate constants
   localparam logic [7:0] PRO_FIRST    = 8'hD5;
   localparam logic [7:0] PRO_SECOND   = 8'hAA;
   localparam logic [7:0] PRO_ADDR_END = 8'h96;
   localparam logic [7:0] PRO_DATA_END = 8'hAD;
   localparam logic [7:0] GCR_BASE     = 8'h96;
   localparam logic [7:0] GCR_INVALID  = 8'hFF;
   localparam int         TAIL_LEN     = 3;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_ADDR_SEARCH = 3'd0,
      PH_ADDR_FIELD  = 3'd1,
      PH_ADDR_TAIL   = 3'd2,
      PH_DATA_SEARCH = 3'd3,
      PH_LOW_BITS    = 3'd4,
      PH_DATA        = 3'd5,
      PH_DATA_TAIL   = 3'd6
   } phase_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_ADDR      = 2'd1,
      KIND_VOL_ERR   = 2'd2,
      KIND_TRACK_ERR = 2'd3
   } kind_type;

   // 6-and-2 read translate table, indexed by nibble minus 0x96
   localparam logic [7:0] GCR_TABLE [0:105] = '{
      8'h00, 8'h01, 8'hFF, 8'hFF, 8'h02, 8'h03, 8'hFF, 8'h04,
      8'h05, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h07, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'h09, 8'h0A, 8'h0B,
      8'h0C, 8'h0D, 8'hFF, 8'hFF, 8'h0E, 8'h0F, 8'h10, 8'h11,
      8'h12, 8'h13, 8'hFF, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
      8'h19, 8'h1A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1B, 8'hFF, 8'h1C,
      8'h1D, 8'h1E, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'hFF, 8'hFF,
      8'h20, 8'h21, 8'hFF, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
      8'h27, 8'h28, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h29,
      8'h2A, 8'h2B, 8'hFF, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30,
      8'h31, 8'h32, 8'hFF, 8'hFF, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'hFF, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
      8'h3E, 8'h3F
   };

   // Physical to logical sector deinterleave
   localparam logic [3:0] SECTOR_MAP [0:15] = '{
      4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
      4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF
   };

   // Translate a disk nibble; anything below the table base is invalid
   function automatic logic [7:0] gcr_translate(input logic [7:0] nib);
      logic [7:0] off;
      off = nib - GCR_BASE;
      if (nib < GCR_BASE) begin
         return GCR_INVALID;
      end
      return GCR_TABLE[off[6:0]];
   endfunction

endpackage

@@ hw/rtl/gcr_sector_nibble_decoder.sv @@
// Sector decoder for a 6-and-2 group-coded nibble stream. Each request carries one disk
// nibble in req_tdata and a track-start flag in req_tuser that clears all decoder state,
// including the remembered volume and any halt, before that nibble. The block hunts for
// the address prologue, reports each decoded address field (kind 1), then hunts for the
// data prologue and emits the 256 data bytes of the sector (kind 0) with sector and byte
// index. A volume or track mismatch gives kind 2 or 3 and halts until the next track
// start. One nibble is taken every clock unless the result channel stalls; a nibble passes
// an input register, then one stage of table lookup, XOR chaining and a read-modify-write
// of the 86-entry low-bit store, into the result register. The store's next slot is
// read on the cycle the previous nibble is processed, which keeps its single write port
// and registered read port at one nibble per clock.
module gcr_sector_nibble_decoder
   import gcrsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,   // expected_track
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] nibble
   input  logic        req_tuser,     // [0] track_start
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [7:0] data_byte, [11:8] sector, [19:12] byte_index,
                                      // [27:20] volume, [28] address_check_ok, [31:29] zero
   output logic [1:0]  rsp_tuser      // [1:0] kind
);

   // Configuration register
   logic [5:0]        exp_track_ff;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_nib_ff;
   logic              in_tstart_ff;

   // Decoder state
   phase_type         phase_ff, phase_in, ph_cur;
   logic [7:0]        count_ff, count_in;
   logic [15:0]       recent_ff, recent_in;
   logic [7:0]        odd_ff, odd_in;
   logic [7:0]        addr_chk_ff, addr_chk_in;
   logic [7:0]        vol_ff, vol_in;
   logic [7:0]        trk_ff, trk_in;
   logic [7:0]        seen_vol_ff, seen_vol_in;
   logic              vol_known_ff, vol_known_in;
   logic [3:0]        sector_ff, sector_in;
   logic [7:0]        acc_ff, acc_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              halted_ff, halted_in;

   // Low-bit store
   logic [7:0]        lbs_mem [0:LOW_BIT_NIBBLES-1];
   logic [7:0]        lbs_rd_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]        rsp_tuser_ff, rsp_tuser_in;

   // Step datapath
   logic              out_free;
   logic              in_load;
   logic              proc_fire;
   logic              emit;
   kind_type          kind;
   logic [7:0]        out_byte;
   logic [7:0]        out_index;
   logic [7:0]        tr;
   logic [7:0]        addr_x;
   logic [1:0]        pair;
   logic              hit;

   // Handshake
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign proc_fire   = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_load     = req_tvalid && req_tready;
   assign in_valid_in = in_load || (in_valid_ff && !proc_fire);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Decode one nibble
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      recent_in    = recent_ff;
      odd_in       = odd_ff;
      addr_chk_in  = addr_chk_ff;
      vol_in       = vol_ff;
      trk_in       = trk_ff;
      seen_vol_in  = seen_vol_ff;
      vol_known_in = vol_known_ff;
      sector_in    = sector_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      halted_in    = halted_ff;
      ph_cur       = phase_ff;
      emit         = 1'b0;
      kind         = KIND_DATA;
      out_byte     = 8'h00;
      out_index    = 8'h00;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = 8'h00;
      tr           = gcr_translate(in_nib_ff);
      addr_x       = {odd_ff[6:0], odd_ff[7]} & in_nib_ff;
      pair         = count_ff[2:1];
      hit          = 1'b0;

      if (proc_fire) begin
         // Drop all state on a track start
         if (in_tstart_ff) begin
            phase_in     = PH_ADDR_SEARCH;
            count_in     = 8'h00;
            recent_in    = 16'h0000;
            odd_in       = 8'h00;
            addr_chk_in  = 8'h00;
            vol_in       = 8'h00;
            trk_in       = 8'h00;
            seen_vol_in  = 8'h00;
            vol_known_in = 1'b0;
            sector_in    = 4'h0;
            acc_in       = 8'h00;
            slot_in      = '0;
            halted_in    = 1'b0;
            ph_cur       = PH_ADDR_SEARCH;
         end
         if (!halted_in) begin
            case (ph_cur)
               PH_ADDR_FIELD: begin
                  if (!count_in[0]) begin
                     odd_in   = in_nib_ff;
                     count_in = count_in + 8'd1;
                  end else begin
                     addr_chk_in = addr_chk_in ^ addr_x;
                     if (pair == 2'd0) begin
                        vol_in = addr_x;
                     end else if (pair == 2'd1) begin
                        trk_in = addr_x;
                     end else if (pair == 2'd2) begin
                        sector_in = SECTOR_MAP[addr_x[3:0]];
                     end
                     count_in = count_in + 8'd1;
                     // Check volume, then track, after the check pair
                     if (pair == 2'd3) begin
                        emit = 1'b1;
                        if (vol_known_in && seen_vol_in != vol_in) begin
                           halted_in = 1'b1;
                           kind      = KIND_VOL_ERR;
                        end else begin
                           seen_vol_in  = vol_in;
                           vol_known_in = 1'b1;
                           if (trk_in != {2'b00, exp_track_ff}) begin
                              halted_in = 1'b1;
                              kind      = KIND_TRACK_ERR;
                           end else begin
                              phase_in = PH_ADDR_TAIL;
                              count_in = 8'h00;
                              kind     = KIND_ADDR;
                           end
                        end
                     end
                  end
               end
               PH_ADDR_TAIL, PH_DATA_TAIL: begin
                  if (count_in >= 8'(TAIL_LEN - 1)) begin
                     phase_in  = (ph_cur == PH_ADDR_TAIL) ? PH_DATA_SEARCH : PH_ADDR_SEARCH;
                     count_in  = 8'h00;
                     recent_in = 16'h0000;
                  end else begin
                     count_in = count_in + 8'd1;
                  end
               end
               PH_DATA_SEARCH: begin
                  hit       = (recent_in == {PRO_FIRST, PRO_SECOND}) &&
                              (in_nib_ff == PRO_DATA_END);
                  recent_in = {recent_in[7:0], in_nib_ff};
                  if (hit) begin
                     phase_in = PH_LOW_BITS;
                     count_in = 8'h00;
                     slot_in  = '0;
                     acc_in   = 8'h00;
                  end
               end
               PH_LOW_BITS: begin
                  // Fill the low-bit store with chained values
                  acc_in    = acc_in ^ tr;
                  mem_we    = 1'b1;
                  mem_waddr = slot_in;
                  mem_wdata = acc_in;
                  if (slot_in == SLOT_W'(LOW_BIT_NIBBLES - 1)) begin
                     phase_in = PH_DATA;
                     count_in = 8'h00;
                     slot_in  = '0;
                  end else begin
                     slot_in = slot_in + SLOT_W'(1);
                  end
               end
               PH_DATA: begin
                  // Merge six high bits with two low bits, shift the store entry down
                  acc_in    = acc_in ^ tr;
                  emit      = 1'b1;
                  kind      = KIND_DATA;
                  out_byte  = {acc_in[5:0], lbs_rd_ff[0], lbs_rd_ff[1]};
                  out_index = count_in;
                  mem_we    = 1'b1;
                  mem_waddr = slot_in;
                  mem_wdata = {2'b00, lbs_rd_ff[7:2]};
                  if (slot_in == SLOT_W'(LOW_BIT_NIBBLES - 1)) begin
                     slot_in = '0;
                  end else begin
                     slot_in = slot_in + SLOT_W'(1);
                  end
                  if (count_in == 8'(SECTOR_SIZE - 1)) begin
                     phase_in = PH_DATA_TAIL;
                     count_in = 8'h00;
                  end else begin
                     count_in = count_in + 8'd1;
                  end
               end
               default: begin
                  // Address search; an unused phase code lands here too
                  hit       = (recent_in == {PRO_FIRST, PRO_SECOND}) &&
                              (in_nib_ff == PRO_ADDR_END);
                  recent_in = {recent_in[7:0], in_nib_ff};
                  if (hit) begin
                     phase_in    = PH_ADDR_FIELD;
                     count_in    = 8'h00;
                     addr_chk_in = 8'h00;
                  end
               end
            endcase
         end
      end

      // Result register next value
      if (proc_fire) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
      rsp_tdata_in = {3'b000, (addr_chk_in == 8'h00), vol_in, out_index, sector_in, out_byte};
      rsp_tuser_in = kind;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_track_ff <= 6'd0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_ADDR_SEARCH;
         count_ff     <= 8'h00;
         recent_ff    <= 16'h0000;
         odd_ff       <= 8'h00;
         addr_chk_ff  <= 8'h00;
         vol_ff       <= 8'h00;
         trk_ff       <= 8'h00;
         seen_vol_ff  <= 8'h00;
         vol_known_ff <= 1'b0;
         sector_ff    <= 4'h0;
         acc_ff       <= 8'h00;
         slot_ff      <= '0;
         halted_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            exp_track_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         recent_ff    <= recent_in;
         odd_ff       <= odd_in;
         addr_chk_ff  <= addr_chk_in;
         vol_ff       <= vol_in;
         trk_ff       <= trk_in;
         seen_vol_ff  <= seen_vol_in;
         vol_known_ff <= vol_known_in;
         sector_ff    <= sector_in;
         acc_ff       <= acc_in;
         slot_ff      <= slot_in;
         halted_ff    <= halted_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_nib_ff    <= req_tdata;
         in_tstart_ff <= req_tuser;
      end
      if (proc_fire && emit) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   // Low-bit store: write the current slot, prefetch the next one
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lbs_mem[mem_waddr] <= mem_wdata;
      end
      if (proc_fire) begin
         lbs_rd_ff <= lbs_mem[slot_in];
      end
   end

   // Store slot never leaves the store
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(LOW_BIT_NIBBLES - 1))
      else $error("low-bit slot out of range");

   // A halt only happens while decoding an address field
   a_halt_phase: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> phase_ff == PH_ADDR_FIELD)
      else $error("halted outside address field");

   // A halted decoder gives no result unless a track start arrives
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && halted_ff && !in_tstart_ff) |=> !rsp_tvalid)
      else $error("result while halted");

   // Every nibble of the data phase yields a data byte
   a_data_emit: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && phase_ff == PH_DATA && !in_tstart_ff)
      |=> rsp_tvalid && rsp_tuser == KIND_DATA)
      else $error("data nibble without data byte");

   // Data bytes start at the first slot of the store
   a_data_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA && $past(phase_ff) == PH_LOW_BITS) |-> slot_ff == '0)
      else $error("data phase entered off slot zero");

endmodule

@@ tb/gcr_sector_nibble_decoder_tb.sv @@
`timescale 1ns / 100ps

module gcr_sector_nibble_decoder_tb;
   import gcrsd_pkg::*;

   localparam int PHASE_ITEMS    = 420;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_AFTER = 300;
   localparam int PRESSURE_HOLD  = 300;
   localparam int DIR_COUNT      = 27;
   localparam int FULL_SECTOR    = LOW_BIT_NIBBLES + SECTOR_SIZE;

   // One decoded result as it leaves the block
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [3:0] sector;
      logic [7:0] byte_index;
      logic [7:0] volume;
      logic       check_ok;
   } decoded_type;

   // Directed row: pinned rows carry a hand-written address or error result
   typedef struct packed {
      logic [7:0] nibble;
      logic       track_start;
      logic       pinned;
      logic [1:0] kind;
      logic [3:0] sector;
      logic [7:0] volume;
      logic       check_ok;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      // track start, address prologue
      '{8'hD5, 1'b1, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'h96, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      // volume FF, track 0, physical sector 1, good check
      '{8'hFF, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hFF, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAB, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hFF, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hFE, 1'b0, 1'b1, KIND_ADDR, 4'h7, 8'hFF, 1'b1},
      // tail carries D5 AA, so the AD after it must not open the data field
      '{8'h00, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hD5, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAD, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      // restart: volume 0, track 1 against expected 0, sector F, bad check
      '{8'hD5, 1'b1, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'h96, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAB, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAF, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAF, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0},
      '{8'hAA, 1'b0, 1'b1, KIND_TRACK_ERR, 4'hF, 8'h00, 1'b0},
      // halted: nothing comes out
      '{8'hD5, 1'b0, 1'b0, KIND_DATA, 4'h0, 8'h00, 1'b0}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [5:0]  csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Decoder shadow state
   logic [5:0]  track_cfg;
   phase_type   dec_phase;
   logic [8:0]  dec_count;
   logic [15:0] dec_recent;
   logic [7:0]  dec_odd;
   logic [7:0]  dec_check;
   logic [7:0]  dec_volume;
   logic [7:0]  dec_track;
   logic [7:0]  dec_seen_vol;
   logic        dec_vol_known;
   logic [3:0]  dec_sector;
   logic [7:0]  dec_chain;
   logic [7:0]  dec_low_bits [LOW_BIT_NIBBLES];
   logic        dec_halted;

   decoded_type decoded_q [$];
   logic [8:0]  stim_q [$];
   int          fail_count   = 0;
   int          results_seen = 0;
   int          burst_left   = 0;
   int          idle_cycles  = 0;

   // Receiver pattern state
   int          rx_mode       = 0;
   int          rx_mode_left  = 0;
   int          rx_cycle      = 0;
   int          hold_left     = 0;
   bit          pressure_done = 1'b0;

   gcr_sector_nibble_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   // 6-and-2 value of a nibble; out-of-range codes read as invalid
   function automatic logic [7:0] nib_value(input logic [7:0] n);
      int idx;
      idx = int'(n) - int'(GCR_BASE);
      if (idx < 0) return GCR_INVALID;
      return GCR_TABLE[idx];
   endfunction

   task automatic clear_decoder();
      dec_phase     = PH_ADDR_SEARCH;
      dec_count     = '0;
      dec_recent    = '0;
      dec_odd       = '0;
      dec_check     = '0;
      dec_volume    = '0;
      dec_track     = '0;
      dec_seen_vol  = '0;
      dec_vol_known = 1'b0;
      dec_sector    = '0;
      dec_chain     = '0;
      dec_halted    = 1'b0;
   endtask

   // Advance the shadow decoder by one nibble and form the result it causes
   task automatic decode_nibble(input logic [7:0] n, input logic ts,
                                output bit has, output decoded_type res);
      logic [7:0] x;
      logic [7:0] lb;
      int         pair;
      int         slot;
      int         j;
      bit         hit;
      has = 1'b0;
      res = '0;
      if (ts) clear_decoder();
      if (!dec_halted) begin
         case (dec_phase)
            PH_ADDR_FIELD: begin
               if (!dec_count[0]) begin
                  dec_odd = n;
                  dec_count++;
               end else begin
                  x = {dec_odd[6:0], dec_odd[7]} & n;
                  pair = int'(dec_count) >> 1;
                  dec_check ^= x;
                  if (pair == 0) dec_volume = x;
                  else if (pair == 1) dec_track = x;
                  else if (pair == 2) dec_sector = SECTOR_MAP[x[3:0]];
                  dec_count++;
                  if (pair == 3) begin
                     has = 1'b1;
                     if (dec_vol_known && dec_seen_vol != dec_volume) begin
                        dec_halted = 1'b1;
                        res.kind = KIND_VOL_ERR;
                     end else begin
                        dec_seen_vol  = dec_volume;
                        dec_vol_known = 1'b1;
                        if (dec_track != {2'b00, track_cfg}) begin
                           dec_halted = 1'b1;
                           res.kind = KIND_TRACK_ERR;
                        end else begin
                           dec_phase = PH_ADDR_TAIL;
                           dec_count = '0;
                           res.kind = KIND_ADDR;
                        end
                     end
                  end
               end
            end
            PH_ADDR_TAIL: begin
               dec_count++;
               if (dec_count >= TAIL_LEN) begin
                  dec_phase  = PH_DATA_SEARCH;
                  dec_count  = '0;
                  dec_recent = '0;
               end
            end
            PH_DATA_SEARCH: begin
               hit = (dec_recent == {PRO_FIRST, PRO_SECOND}) && (n == PRO_DATA_END);
               dec_recent = {dec_recent[7:0], n};
               if (hit) begin
                  dec_phase = PH_LOW_BITS;
                  dec_count = '0;
                  dec_chain = '0;
               end
            end
            PH_LOW_BITS: begin
               dec_chain ^= nib_value(n);
               dec_low_bits[dec_count[6:0]] = dec_chain;
               dec_count++;
               if (dec_count >= LOW_BIT_NIBBLES) begin
                  dec_phase = PH_DATA;
                  dec_count = '0;
               end
            end
            PH_DATA: begin
               j = int'(dec_count);
               slot = j % LOW_BIT_NIBBLES;
               lb = dec_low_bits[slot];
               dec_chain ^= nib_value(n);
               has = 1'b1;
               res.kind = KIND_DATA;
               res.data_byte = {dec_chain[5:0], lb[0], lb[1]};
               res.byte_index = j[7:0];
               dec_low_bits[slot] = lb >> 2;
               dec_count++;
               if (dec_count >= SECTOR_SIZE) begin
                  dec_phase = PH_DATA_TAIL;
                  dec_count = '0;
               end
            end
            PH_DATA_TAIL: begin
               dec_count++;
               if (dec_count >= TAIL_LEN) begin
                  dec_phase  = PH_ADDR_SEARCH;
                  dec_count  = '0;
                  dec_recent = '0;
               end
            end
            default: begin
               hit = (dec_recent == {PRO_FIRST, PRO_SECOND}) && (n == PRO_ADDR_END);
               dec_recent = {dec_recent[7:0], n};
               if (hit) begin
                  dec_phase = PH_ADDR_FIELD;
                  dec_count = '0;
                  dec_check = '0;
               end
            end
         endcase
         if (has) begin
            res.sector   = dec_sector;
            res.volume   = dec_volume;
            res.check_ok = (dec_check == 8'h00);
         end
      end
   endtask

   // Offer one request, honoring the burst/gap pattern, and predict on acceptance
   task automatic send_req(input logic [7:0] n, input logic ts,
                           input logic pinned, input decoded_type fixed);
      bit          has;
      decoded_type res;
      int          gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                  : $urandom_range(1, 30);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= n;
      req_tuser  <= ts;
      do @(posedge clock); while (!req_tready);
      decode_nibble(n, ts, has, res);
      if (pinned) decoded_q.push_back(fixed);
      else if (has) decoded_q.push_back(res);
   endtask

   // Drop valid, wait for every pending result, then let the pipeline empty
   task automatic settle_idle(input int cycles);
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_track(input logic [5:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      track_cfg    = value;
   endtask

   task automatic queue_nib(input logic [7:0] n, input logic ts);
      stim_q.push_back({ts, n});
   endtask

   // 4-and-4: odd bits first, then even bits
   task automatic queue_pair(input logic [7:0] value);
      queue_nib((value >> 1) | 8'hAA, 1'b0);
      queue_nib(value | 8'hAA, 1'b0);
   endtask

   task automatic queue_addr(input logic [7:0] vol, input logic [7:0] trk,
                             input logic [7:0] sec, input logic [7:0] flip);
      queue_nib(PRO_FIRST, 1'b0);
      queue_nib(PRO_SECOND, 1'b0);
      queue_nib(PRO_ADDR_END, 1'b0);
      queue_pair(vol);
      queue_pair(trk);
      queue_pair(sec);
      queue_pair(vol ^ trk ^ sec ^ flip);
      queue_nib(8'hDE, 1'b0);
      queue_nib(8'hAA, 1'b0);
      queue_nib(8'hEB, 1'b0);
   endtask

   function automatic logic [7:0] pick_code();
      int i;
      do i = $urandom_range(0, 105); while (GCR_TABLE[i] == GCR_INVALID);
      return GCR_BASE + i[7:0];
   endfunction

   // Data field of len nibbles, sometimes after a bare address prologue; a full one gets checksum and epilogue
   task automatic queue_sector(input int len);
      if ($urandom_range(0, 3) == 0) begin
         queue_nib(PRO_FIRST, 1'b0);
         queue_nib(PRO_SECOND, 1'b0);
         queue_nib(PRO_ADDR_END, 1'b0);
      end
      queue_nib(PRO_FIRST, 1'b0);
      queue_nib(PRO_SECOND, 1'b0);
      queue_nib(PRO_DATA_END, 1'b0);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) queue_nib(8'($urandom_range(0, 255)), 1'b0);
         else queue_nib(pick_code(), 1'b0);
      end
      if (len == FULL_SECTOR) begin
         queue_nib(pick_code(), 1'b0);
         queue_nib(8'hDE, 1'b0);
         queue_nib(8'hAA, 1'b0);
      end
   endtask

   // Good sectors mixed with error fields, cut-off data, bare address fields and noise between
   task automatic build_phase(input logic [5:0] trk);
      logic [7:0] vol;
      logic [7:0] good_trk;
      int         r;
      int         sub;
      vol = 8'($urandom_range(0, 255));
      good_trk = {2'b00, trk};
      queue_nib(8'hFF, 1'b1);
      queue_addr(vol, good_trk, 8'($urandom_range(0, 15)), 8'h00);
      queue_sector(FULL_SECTOR);
      while (stim_q.size() < PHASE_ITEMS) begin
         queue_nib(8'hFF, $urandom_range(0, 2) == 0);
         repeat ($urandom_range(0, 4)) queue_nib(8'hFF, 1'b0);
         r = $urandom_range(0, 99);
         if (r < 15) begin
            queue_addr(vol, good_trk, 8'($urandom_range(0, 15)), 8'h00);
            queue_sector(FULL_SECTOR);
         end else if (r < 45) begin
            sub = $urandom_range(0, 2);
            if (sub == 0)
               queue_addr(vol ^ 8'($urandom_range(1, 255)), good_trk,
                          8'($urandom_range(0, 15)), 8'h00);
            else if (sub == 1)
               queue_addr(vol, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'h00);
            else
               queue_addr(vol, good_trk, 8'($urandom_range(0, 15)),
                          8'($urandom_range(1, 255)));
         end else if (r < 65) begin
            queue_addr(vol, good_trk, 8'($urandom_range(0, 15)), 8'h00);
            queue_sector($urandom_range(1, 120));
         end else if (r < 80) begin
            repeat ($urandom_range(3, 20))
               queue_nib(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            queue_addr(vol, good_trk, 8'($urandom_range(0, 15)), 8'h00);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : rsp_check
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = decoded_q.pop_front();
            check_field("kind", {6'd0, want.kind}, {6'd0, rsp_tuser});
            check_field("data_byte", want.data_byte, rsp_tdata[7:0]);
            check_field("sector", {4'd0, want.sector}, {4'd0, rsp_tdata[11:8]});
            check_field("byte_index", want.byte_index, rsp_tdata[19:12]);
            check_field("volume", want.volume, rsp_tdata[27:20]);
            check_field("address_check_ok", {7'd0, want.check_ok}, {7'd0, rsp_tdata[28]});
            check_field("tdata pad", 8'd0, {5'd0, rsp_tdata[31:29]});
         end
      end
   end

   // Receiver: switch between stall patterns, plus one long hold-off
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
         pressure_done <= 1'b1;
         hold_left     <= PRESSURE_HOLD;
         rsp_tready    <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(10, 200);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= 1'(8'b1101_0110 >> (rx_cycle % 8));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results pending", $time, decoded_q.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      decoded_type pin_res;
      logic [8:0]  s;
      logic [5:0]  track_list [3];
      int          k;
      track_cfg = '0;
      clear_decoder();
      for (k = 0; k < LOW_BIT_NIBBLES; k++) dec_low_bits[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at the reset track setting
      for (k = 0; k < DIR_COUNT; k++) begin
         pin_res            = '0;
         pin_res.kind       = kind_type'(DIR_ROWS[k].kind);
         pin_res.sector     = DIR_ROWS[k].sector;
         pin_res.volume     = DIR_ROWS[k].volume;
         pin_res.check_ok   = DIR_ROWS[k].check_ok;
         send_req(DIR_ROWS[k].nibble, DIR_ROWS[k].track_start, DIR_ROWS[k].pinned, pin_res);
      end
      settle_idle(SETTLE_CYCLES);

      // Random phases, one track setting each
      track_list = '{6'd34, 6'd63, 6'($urandom_range(0, 34))};
      for (k = 0; k < 3; k++) begin
         write_track(track_list[k]);
         build_phase(track_list[k]);
         while (stim_q.size() != 0) begin
            s = stim_q.pop_front();
            send_req(s[7:0], s[8], 1'b0, '0);
         end
         settle_idle(SETTLE_CYCLES);
      end

      settle_idle(DRAIN_CYCLES);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/gcrsd_pkg.sv
hw/rtl/gcr_sector_nibble_decoder.sv
tb/gcr_sector_nibble_decoder_tb.sv
